[hdl/flt_pkg.sv]
// Package for the filter language tokenizer.
// Token and error codes, character constants, lexer modes and result types.
// No dependencies.
package flt_pkg;

    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QUEUE_CW-1:0] QUEUE_ACCEPT_MAX = QUEUE_CW'(QUEUE_DEPTH - 4);

    localparam logic [4:0] TOK_EOF      = 5'd0;
    localparam logic [4:0] TOK_LPAREN   = 5'd1;
    localparam logic [4:0] TOK_RPAREN   = 5'd2;
    localparam logic [4:0] TOK_COMMA    = 5'd3;
    localparam logic [4:0] TOK_COLON    = 5'd4;
    localparam logic [4:0] TOK_SEMI     = 5'd5;
    localparam logic [4:0] TOK_LBRACKET = 5'd6;
    localparam logic [4:0] TOK_RBRACKET = 5'd7;
    localparam logic [4:0] TOK_LBRACE   = 5'd8;
    localparam logic [4:0] TOK_RBRACE   = 5'd9;
    localparam logic [4:0] TOK_AND      = 5'd10;
    localparam logic [4:0] TOK_OR       = 5'd11;
    localparam logic [4:0] TOK_EQ       = 5'd12;
    localparam logic [4:0] TOK_ASSIGN   = 5'd13;
    localparam logic [4:0] TOK_LT       = 5'd14;
    localparam logic [4:0] TOK_LE       = 5'd15;
    localparam logic [4:0] TOK_GT       = 5'd16;
    localparam logic [4:0] TOK_GE       = 5'd17;
    localparam logic [4:0] TOK_ID       = 5'd18;
    localparam logic [4:0] TOK_STRING   = 5'd19;
    localparam logic [4:0] TOK_INT32    = 5'd20;
    localparam logic [4:0] TOK_INT64    = 5'd21;
    localparam logic [4:0] TOK_TEXT     = 5'd22;
    localparam logic [4:0] TOK_ERR      = 5'd23;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
    localparam logic [2:0] ERR_UNTERM   = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_UNSUP    = 3'd4;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_EQ       = 8'h3D;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_L  = 8'h4C;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_L  = 8'h6C;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_VBAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_TILDE    = 8'h7E;

    localparam logic [63:0] ACC_LIM_LO = 64'd922337203685477580;
    localparam logic [63:0] ACC_LIM_HI = 64'd922337203685477579;
    localparam logic [23:0] LINE_MAX   = 24'hFFFFFF;

    typedef enum logic [12:0] {
        M_START   = 13'h0001,
        M_COMMENT = 13'h0002,
        M_AMP     = 13'h0004,
        M_VBAR    = 13'h0008,
        M_EQ      = 13'h0010,
        M_LT      = 13'h0020,
        M_GT      = 13'h0040,
        M_DEC     = 13'h0080,
        M_ID      = 13'h0100,
        M_DQ      = 13'h0200,
        M_SQ      = 13'h0400,
        M_UNSUP   = 13'h0800,
        M_HALT    = 13'h1000
    } t_mode;

    typedef struct packed {
        logic [4:0]         token_code;
        logic [7:0]         text_byte;
        logic signed [63:0] number_value;
        logic [2:0]         error_code;
        logic [23:0]        line_number;
        logic               last_in_run;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_core_out;

endpackage

[hdl/flt_ifs.sv]
// Valid/ready stream interfaces for the tokenizer's input and result channels.
// Depends on nothing.
interface flt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface flt_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         token_code;
    logic [7:0]         text_byte;
    logic signed [63:0] number_value;
    logic [2:0]         error_code;
    logic [23:0]        line_number;
    logic               last_in_run;

    modport source (output valid, output token_code, output text_byte, output number_value,
                    output error_code, output line_number, output last_in_run, input ready);
    modport sink (input valid, input token_code, input text_byte, input number_value,
                  input error_code, input line_number, input last_in_run, output ready);
endinterface

[hdl/flt_core.sv]
// Lexer core: mode, number accumulator and line counter, and the one-pass
// next-state logic that turns one registered item into up to two results. Uses flt_pkg.
module flt_core
    import flt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_eof,
    output t_core_out  o_out
);

    typedef struct packed {
        logic [4:0]  code;
        logic [7:0]  text;
        logic [63:0] num;
        logic [2:0]  err;
    } t_tok;

    typedef struct packed {
        t_mode       mode;
        logic        emit;
        t_tok        tok;
        logic [63:0] acc;
    } t_start;

    localparam t_tok TOK_NONE = '{code: TOK_EOF, text: 8'd0, num: 64'd0, err: ERR_NONE};

    function automatic logic f_is_ws(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic f_id_cont(input logic [7:0] c);
        logic bad;
        bad = c == CH_DQUOTE || c == CH_SQUOTE || c == CH_LPAREN || c == CH_RPAREN ||
              c == CH_COMMA || c == CH_COLON || c == CH_SEMI || c == CH_BSLASH;
        return c > CH_SPACE && c <= CH_TILDE && !bad;
    endfunction

    function automatic t_start f_start(input logic [7:0] c, input logic eof);
        t_start s;
        s.mode = M_START;
        s.emit = 1'b0;
        s.tok  = TOK_NONE;
        s.acc  = 64'd0;
        if (eof) begin
            s.emit = 1'b1;
        end else begin
            unique case (c)
                CH_BANG, CH_BSLASH, CH_ZERO: s.mode = M_UNSUP;
                CH_HASH:   s.mode = M_COMMENT;
                CH_DQUOTE: s.mode = M_DQ;
                CH_SQUOTE: s.mode = M_SQ;
                CH_AMP:    s.mode = M_AMP;
                CH_VBAR:   s.mode = M_VBAR;
                CH_EQ:     s.mode = M_EQ;
                CH_LT:     s.mode = M_LT;
                CH_GT:     s.mode = M_GT;
                CH_LPAREN: begin s.emit = 1'b1; s.tok.code = TOK_LPAREN; end
                CH_RPAREN: begin s.emit = 1'b1; s.tok.code = TOK_RPAREN; end
                CH_COMMA: begin s.emit = 1'b1; s.tok.code = TOK_COMMA; end
                CH_COLON: begin s.emit = 1'b1; s.tok.code = TOK_COLON; end
                CH_SEMI: begin s.emit = 1'b1; s.tok.code = TOK_SEMI; end
                CH_LBRACKET: begin s.emit = 1'b1; s.tok.code = TOK_LBRACKET; end
                CH_RBRACKET: begin s.emit = 1'b1; s.tok.code = TOK_RBRACKET; end
                CH_LBRACE: begin s.emit = 1'b1; s.tok.code = TOK_LBRACE; end
                CH_RBRACE: begin s.emit = 1'b1; s.tok.code = TOK_RBRACE; end
                default: begin
                    if (f_is_ws(c)) begin
                        s.mode = M_START;
                    end else if (c >= CH_ONE && c <= CH_NINE) begin
                        s.mode = M_DEC;
                        s.acc  = {60'd0, c[3:0]};
                    end else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                                 (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDER) begin
                        s.mode     = M_ID;
                        s.emit     = 1'b1;
                        s.tok.code = TOK_TEXT;
                        s.tok.text = c;
                    end else begin
                        s.mode     = M_HALT;
                        s.emit     = 1'b1;
                        s.tok.code = TOK_ERR;
                        s.tok.err  = ERR_BAD_CHAR;
                    end
                end
            endcase
        end
        return s;
    endfunction

    function automatic t_result f_res(input t_tok t, input logic [23:0] line, input logic last);
        t_result r;
        r.token_code   = t.code;
        r.text_byte    = t.text;
        r.number_value = t.num;
        r.error_code   = t.err;
        r.line_number  = line;
        r.last_in_run  = last;
        return r;
    endfunction

    t_mode       r_mode;
    t_mode       n_mode;
    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic [23:0] r_line;
    logic [23:0] n_line;

    t_start      st;
    t_tok        first;
    logic        first_en;
    logic        chain;
    logic        fail_en;
    logic [2:0]  fail_err;
    logic [3:0]  digit;
    logic [63:0] acc_lim;
    logic [63:0] acc_next;
    logic        is_digit;
    logic [7:0]  quote;

    always_comb begin
        st       = f_start(i_char, i_eof);
        first    = TOK_NONE;
        first_en = 1'b0;
        chain    = 1'b0;
        fail_en  = 1'b0;
        fail_err = ERR_NONE;
        n_mode   = r_mode;
        n_acc    = r_acc;
        digit    = i_char[3:0];
        is_digit = !i_eof && i_char >= CH_ZERO && i_char <= CH_NINE;
        acc_lim  = (digit > 4'd7) ? ACC_LIM_HI : ACC_LIM_LO;
        acc_next = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0} + {60'd0, digit};
        quote    = (r_mode == M_DQ) ? CH_DQUOTE : CH_SQUOTE;

        if (i_valid) begin
            unique case (r_mode)
                M_START: chain = 1'b1;
                M_COMMENT: begin
                    if (i_eof) begin
                        chain = 1'b1;
                    end else if (i_char == CH_LF) begin
                        n_mode = M_START;
                    end
                end
                M_AMP, M_VBAR: begin
                    if (!i_eof && i_char == ((r_mode == M_AMP) ? CH_AMP : CH_VBAR)) begin
                        first_en   = 1'b1;
                        first.code = (r_mode == M_AMP) ? TOK_AND : TOK_OR;
                        n_mode     = M_START;
                    end else begin
                        fail_en  = 1'b1;
                        fail_err = ERR_BAD_CHAR;
                    end
                end
                M_EQ, M_LT, M_GT: begin
                    first_en = 1'b1;
                    if (!i_eof && i_char == CH_EQ) begin
                        first.code = (r_mode == M_EQ) ? TOK_EQ :
                                     (r_mode == M_LT) ? TOK_LE : TOK_GE;
                        n_mode     = M_START;
                    end else begin
                        first.code = (r_mode == M_EQ) ? TOK_ASSIGN :
                                     (r_mode == M_LT) ? TOK_LT : TOK_GT;
                        chain      = 1'b1;
                    end
                end
                M_DEC: begin
                    priority if (is_digit) begin
                        if (r_acc > acc_lim) begin
                            fail_en  = 1'b1;
                            fail_err = ERR_OVERFLOW;
                        end else begin
                            n_acc = acc_next;
                        end
                    end else if (!i_eof && i_char == CH_DOT) begin
                        n_acc  = 64'd0;
                        n_mode = M_UNSUP;
                    end else if (!i_eof && (i_char == CH_UPPER_L || i_char == CH_LOWER_L)) begin
                        first_en   = 1'b1;
                        first.code = TOK_INT64;
                        first.num  = r_acc;
                        n_acc      = 64'd0;
                        n_mode     = M_START;
                    end else if (r_acc[63:31] != 33'd0) begin
                        fail_en  = 1'b1;
                        fail_err = ERR_OVERFLOW;
                    end else begin
                        first_en   = 1'b1;
                        first.code = TOK_INT32;
                        first.num  = r_acc;
                        chain      = 1'b1;
                    end
                end
                M_ID: begin
                    priority if (!i_eof && i_char == CH_BSLASH) begin
                        n_mode = M_UNSUP;
                    end else if (!i_eof && f_id_cont(i_char)) begin
                        first_en   = 1'b1;
                        first.code = TOK_TEXT;
                        first.text = i_char;
                    end else begin
                        first_en   = 1'b1;
                        first.code = TOK_ID;
                        chain      = 1'b1;
                    end
                end
                M_DQ, M_SQ: begin
                    priority if (i_eof) begin
                        fail_en  = 1'b1;
                        fail_err = ERR_UNTERM;
                    end else if (i_char == CH_BSLASH) begin
                        n_mode = M_UNSUP;
                    end else if (i_char == quote) begin
                        first_en   = 1'b1;
                        first.code = TOK_STRING;
                        n_mode     = M_START;
                    end else begin
                        first_en   = 1'b1;
                        first.code = TOK_TEXT;
                        first.text = i_char;
                    end
                end
                M_UNSUP: begin
                    fail_en  = 1'b1;
                    fail_err = ERR_UNSUP;
                end
                M_HALT: n_mode = M_HALT;
                default: n_mode = r_mode;
            endcase
        end

        if (chain) begin
            n_mode = st.mode;
            n_acc  = st.acc;
        end
        if (fail_en) begin
            first_en   = 1'b1;
            first      = TOK_NONE;
            first.code = TOK_ERR;
            first.err  = fail_err;
            n_mode     = M_HALT;
            n_acc      = 64'd0;
        end

        o_out.num  = 2'd0;
        o_out.res0 = f_res(TOK_NONE, r_line, 1'b0);
        o_out.res1 = f_res(TOK_NONE, r_line, 1'b0);
        if (first_en) begin
            if (chain && st.emit) begin
                o_out.num  = 2'd2;
                o_out.res0 = f_res(first, r_line, 1'b0);
                o_out.res1 = f_res(st.tok, r_line, 1'b1);
            end else begin
                o_out.num  = 2'd1;
                o_out.res0 = f_res(first, r_line, 1'b1);
            end
        end else if (chain && st.emit) begin
            o_out.num  = 2'd1;
            o_out.res0 = f_res(st.tok, r_line, 1'b1);
        end

        n_line = r_line;
        if (i_valid && r_mode != M_HALT && n_mode != M_HALT && !i_eof && i_char == CH_LF &&
            r_line != LINE_MAX) begin
            n_line = r_line + 24'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_acc  <= 64'd0;
            r_line <= 24'd1;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_line <= n_line;
        end
    end

endmodule

[hdl/flt_rqueue.sv]
// Result queue: takes up to two results a cycle from the lexer core and
// presents one result a cycle on the output channel while it is ready. Uses flt_pkg and flt_out_if.
module flt_rqueue
    import flt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_core_out           i_push,
    output logic [QUEUE_CW-1:0] o_count,
    flt_out_if.source           o_out
);

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW-1:0]   n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic [QUEUE_CW-1:0]   n_count;
    logic                  pop;
    t_result               head;

    assign head = r_mem[r_rd_ptr];
    assign pop  = o_out.valid && o_out.ready;

    assign o_out.valid        = r_count != '0;
    assign o_out.token_code   = head.token_code;
    assign o_out.text_byte    = head.text_byte;
    assign o_out.number_value = head.number_value;
    assign o_out.error_code   = head.error_code;
    assign o_out.line_number  = head.line_number;
    assign o_out.last_in_run  = head.last_in_run;
    assign o_count            = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_AW'(i_push.num);
        n_rd_ptr = r_rd_ptr + QUEUE_AW'(pop);
        n_count  = r_count + QUEUE_CW'(i_push.num) - QUEUE_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr_ptr + QUEUE_AW'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[hdl/filter_language_tokenizer.sv]
// Filter language tokenizer: takes one character byte or an end-of-input mark
// per transfer and returns tokens, up to two per item. An item is registered on
// transfer, lexed in the next cycle and its results enter an eight-entry queue.
// One item is taken every cycle while the queue holds four results or fewer; an
// item that ends an identifier, a number or a one-character operator can yield
// two results, and such items set the sustained rate. After an error the block
// emits nothing until reset. Depends on flt_pkg, flt_ifs, flt_core and flt_rqueue.
module filter_language_tokenizer
    import flt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    flt_in_if.sink    i_in,
    flt_out_if.source o_out
);

    logic                r_in_valid;
    logic [7:0]          r_in_char;
    logic                r_in_eof;
    logic [QUEUE_CW-1:0] queue_count;
    t_core_out           core_out;

    assign i_in.ready = queue_count <= QUEUE_ACCEPT_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in.valid && i_in.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_char <= i_in.char_byte;
        r_in_eof  <= i_in.end_of_input;
    end

    flt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_char  (r_in_char),
        .i_eof   (r_in_eof),
        .o_out   (core_out)
    );

    flt_rqueue u_rqueue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_out),
        .o_count (queue_count),
        .o_out   (o_out)
    );

endmodule

[hdl/flt_checker.sv]
// Port-level checks on the tokenizer's result channel, bound to the top level.
// Uses flt_pkg.
module flt_checker
    import flt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_token_code,
    input logic [7:0]  i_text_byte,
    input logic [2:0]  i_error_code,
    input logic [23:0] i_line_number,
    input logic        i_last_in_run
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_token_code) && $stable(i_text_byte) &&
            $stable(i_line_number))
        else $error("result changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_token_code == TOK_ERR |-> i_last_in_run)
        else $error("error result is not last of its run");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_token_code == TOK_ERR) == (i_error_code != ERR_NONE)))
        else $error("error code does not match token");

    a_text_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_token_code != TOK_TEXT |-> i_text_byte == 8'd0)
        else $error("text byte set on non-text token");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_line_number != 24'd0)
        else $error("line number is zero");

endmodule

bind filter_language_tokenizer flt_checker u_flt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_token_code  (o_out.token_code),
    .i_text_byte   (o_out.text_byte),
    .i_error_code  (o_out.error_code),
    .i_line_number (o_out.line_number),
    .i_last_in_run (o_out.last_in_run)
);

[tb/sv/filter_language_tokenizer_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for filter_language_tokenizer: streams characters through
// valid/ready channels, predicts every token and compares it as it leaves the block.
// Depends on flt_pkg, flt_ifs and the tokenizer RTL.
module filter_language_tokenizer_test;
    import flt_pkg::*;

    localparam logic [63:0] INT64_TOP   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT32_TOP   = 64'h0000_0000_7FFF_FFFF;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS = 450;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } t_char_item;

    logic i_clk;
    logic i_rst_n;

    flt_in_if  char_ch ();
    flt_out_if token_ch ();

    filter_language_tokenizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_ch),
        .o_out   (token_ch)
    );

    t_char_item  char_queue[$];
    t_result     token_fifo[$];
    t_result     run_buf[2];
    int          run_n;

    t_mode       lex_mode;
    logic [63:0] lex_acc;
    logic [23:0] lex_line;

    int          fault_count  = 0;
    int          chars_total  = 0;
    int          chars_taken  = 0;
    int          tokens_seen  = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    int unsigned stall_cycles = 0;

    string punct_set  = "()[]{},:;";
    string break_set  = "(),:;";
    string op_set [8] = '{"&&", "||", "==", "=", "<", "<=", ">", ">="};

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        char_ch.valid        = 1'b0;
        char_ch.char_byte    = '0;
        char_ch.end_of_input = 1'b0;
        token_ch.ready       = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_fault(input string msg);
        $display("ERROR: result %0d: %s", tokens_seen, msg);
        fault_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // ---------------- token prediction ----------------

    function automatic logic id_follow(input logic [7:0] c);
        if (c < CH_BANG || c > CH_TILDE) begin
            return 1'b0;
        end
        return !(c inside {CH_DQUOTE, CH_SQUOTE, CH_LPAREN, CH_RPAREN, CH_COMMA,
                           CH_COLON, CH_SEMI, CH_BSLASH});
    endfunction

    task automatic add_token(input logic [4:0] code, input logic [7:0] tb_val,
                             input logic [63:0] num, input logic [2:0] err);
        t_result r;
        r.token_code   = code;
        r.text_byte    = tb_val;
        r.number_value = num;
        r.error_code   = err;
        r.line_number  = '0;
        r.last_in_run  = 1'b0;
        if (run_n < 2) begin
            run_buf[run_n] = r;
            run_n++;
        end
    endtask

    task automatic halt_on(input logic [2:0] err);
        add_token(TOK_ERR, '0, '0, err);
        lex_mode = M_HALT;
        lex_acc  = '0;
    endtask

    task automatic lex_from_start(input logic [7:0] c, input logic eoi);
        lex_mode = M_START;
        if (eoi) begin
            add_token(TOK_EOF, '0, '0, ERR_NONE);
        end else begin
            case (c)
                CH_BANG, CH_BSLASH, CH_ZERO: lex_mode = M_UNSUP;
                CH_HASH:     lex_mode = M_COMMENT;
                CH_DQUOTE:   lex_mode = M_DQ;
                CH_SQUOTE:   lex_mode = M_SQ;
                CH_AMP:      lex_mode = M_AMP;
                CH_VBAR:     lex_mode = M_VBAR;
                CH_EQ:       lex_mode = M_EQ;
                CH_LT:       lex_mode = M_LT;
                CH_GT:       lex_mode = M_GT;
                CH_LPAREN:   add_token(TOK_LPAREN, '0, '0, ERR_NONE);
                CH_RPAREN:   add_token(TOK_RPAREN, '0, '0, ERR_NONE);
                CH_COMMA:    add_token(TOK_COMMA, '0, '0, ERR_NONE);
                CH_COLON:    add_token(TOK_COLON, '0, '0, ERR_NONE);
                CH_SEMI:     add_token(TOK_SEMI, '0, '0, ERR_NONE);
                CH_LBRACKET: add_token(TOK_LBRACKET, '0, '0, ERR_NONE);
                CH_RBRACKET: add_token(TOK_RBRACKET, '0, '0, ERR_NONE);
                CH_LBRACE:   add_token(TOK_LBRACE, '0, '0, ERR_NONE);
                CH_RBRACE:   add_token(TOK_RBRACE, '0, '0, ERR_NONE);
                default: begin
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                        lex_mode = M_START;
                    end else if (c >= CH_ONE && c <= CH_NINE) begin
                        lex_acc  = 64'(c - CH_ZERO);
                        lex_mode = M_DEC;
                    end else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                                 (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDER) begin
                        add_token(TOK_TEXT, c, '0, ERR_NONE);
                        lex_mode = M_ID;
                    end else begin
                        halt_on(ERR_BAD_CHAR);
                    end
                end
            endcase
        end
    endtask

    task automatic lex_quoted(input logic [7:0] c, input logic eoi, input logic [7:0] quote);
        if (eoi) begin
            halt_on(ERR_UNTERM);
        end else if (c == CH_BSLASH) begin
            lex_mode = M_UNSUP;
        end else if (c == quote) begin
            add_token(TOK_STRING, '0, '0, ERR_NONE);
            lex_mode = M_START;
        end else begin
            add_token(TOK_TEXT, c, '0, ERR_NONE);
        end
    endtask

    task automatic lex_pair(input logic [7:0] c, input logic eoi,
                            input logic [4:0] both, input logic [4:0] single);
        if (!eoi && c == CH_EQ) begin
            add_token(both, '0, '0, ERR_NONE);
            lex_mode = M_START;
        end else begin
            add_token(single, '0, '0, ERR_NONE);
            lex_from_start(c, eoi);
        end
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic eoi);
        logic [23:0] line_now;
        logic [63:0] digit;
        if (lex_mode != M_HALT) begin
            run_n    = 0;
            line_now = lex_line;
            case (lex_mode)
                M_COMMENT: begin
                    if (eoi) begin
                        lex_from_start(c, eoi);
                    end else if (c == CH_LF) begin
                        lex_mode = M_START;
                    end
                end
                M_AMP: begin
                    if (!eoi && c == CH_AMP) begin
                        add_token(TOK_AND, '0, '0, ERR_NONE);
                        lex_mode = M_START;
                    end else begin
                        halt_on(ERR_BAD_CHAR);
                    end
                end
                M_VBAR: begin
                    if (!eoi && c == CH_VBAR) begin
                        add_token(TOK_OR, '0, '0, ERR_NONE);
                        lex_mode = M_START;
                    end else begin
                        halt_on(ERR_BAD_CHAR);
                    end
                end
                M_EQ: lex_pair(c, eoi, TOK_EQ, TOK_ASSIGN);
                M_LT: lex_pair(c, eoi, TOK_LE, TOK_LT);
                M_GT: lex_pair(c, eoi, TOK_GE, TOK_GT);
                M_DEC: begin
                    if (!eoi && c >= CH_ZERO && c <= CH_NINE) begin
                        digit = 64'(c - CH_ZERO);
                        if (lex_acc > (INT64_TOP - digit) / 10) begin
                            halt_on(ERR_OVERFLOW);
                        end else begin
                            lex_acc = lex_acc * 10 + digit;
                        end
                    end else if (!eoi && c == CH_DOT) begin
                        lex_acc  = '0;
                        lex_mode = M_UNSUP;
                    end else if (!eoi && (c == CH_UPPER_L || c == CH_LOWER_L)) begin
                        add_token(TOK_INT64, '0, lex_acc, ERR_NONE);
                        lex_acc  = '0;
                        lex_mode = M_START;
                    end else if (lex_acc > INT32_TOP) begin
                        halt_on(ERR_OVERFLOW);
                    end else begin
                        add_token(TOK_INT32, '0, lex_acc, ERR_NONE);
                        lex_acc = '0;
                        lex_from_start(c, eoi);
                    end
                end
                M_ID: begin
                    if (!eoi && c == CH_BSLASH) begin
                        lex_mode = M_UNSUP;
                    end else if (!eoi && id_follow(c)) begin
                        add_token(TOK_TEXT, c, '0, ERR_NONE);
                    end else begin
                        add_token(TOK_ID, '0, '0, ERR_NONE);
                        lex_from_start(c, eoi);
                    end
                end
                M_DQ:    lex_quoted(c, eoi, CH_DQUOTE);
                M_SQ:    lex_quoted(c, eoi, CH_SQUOTE);
                M_UNSUP: halt_on(ERR_UNSUP);
                default: lex_from_start(c, eoi);
            endcase
            if (lex_mode != M_HALT && !eoi && c == CH_LF && lex_line != LINE_MAX) begin
                lex_line++;
            end
            for (int k = 0; k < run_n; k++) begin
                run_buf[k].line_number = line_now;
                run_buf[k].last_in_run = (k == run_n - 1);
                token_fifo.push_back(run_buf[k]);
            end
        end
    endtask

    // ---------------- character stream ----------------

    task automatic put_char(input logic [7:0] c);
        char_queue.push_back('{ch: c, eoi: 1'b0});
    endtask

    task automatic put_eoi();
        char_queue.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_char(s[i]);
        end
    endtask

    task automatic put_space();
        if ($urandom_range(0, 1)) begin
            put_char(CH_SPACE);
        end else begin
            put_char(8'($urandom_range(CH_TAB, CH_CR)));
        end
    endtask

    task automatic put_string();
        logic [7:0] quote;
        logic [7:0] b;
        quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        put_char(quote);
        repeat ($urandom_range(0, 8)) begin
            do begin
                b = 8'($urandom_range(0, 255));
            end while (b == quote || b == CH_BSLASH);
            put_char(b);
        end
        put_char(quote);
    endtask

    // hold identifiers and numbers apart from whatever comes next
    task automatic put_break();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            put_space();
        end else if (r < 70) begin
            put_char(break_set[$urandom_range(0, break_set.len() - 1)]);
        end else if (r < 80) begin
            put_eoi();
        end else begin
            put_string();
        end
    endtask

    task automatic put_number(input logic [63:0] v, input logic long_form);
        put_text($sformatf("%0d", v));
        if (long_form) begin
            put_char($urandom_range(0, 1) ? CH_UPPER_L : CH_LOWER_L);
        end
        put_break();
    endtask

    task automatic put_ident();
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(0, 52);
        if (r < 26) begin
            b = CH_UPPER_A + 8'(r);
        end else if (r < 52) begin
            b = CH_LOWER_A + 8'(r - 26);
        end else begin
            b = CH_UNDER;
        end
        put_char(b);
        repeat ($urandom_range(0, 6)) begin
            do begin
                b = 8'($urandom_range(CH_BANG, CH_TILDE));
            end while (!id_follow(b));
            put_char(b);
        end
        put_break();
    endtask

    task automatic put_random_number();
        logic        long_form;
        logic [63:0] v;
        long_form = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0: v = 64'($urandom_range(1, 99));
            1: v = long_form ? INT64_TOP : INT32_TOP;
            2: v = long_form ? ({$urandom, $urandom} & INT64_TOP) : (64'($urandom) & INT32_TOP);
            default: v = 64'($urandom_range(1, 100000));
        endcase
        if (v == 0) begin
            v = 1;
        end
        put_number(v, long_form);
    endtask

    task automatic put_token();
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            put_ident();
        end else if (r < 35) begin
            put_random_number();
        end else if (r < 50) begin
            put_char(punct_set[$urandom_range(0, punct_set.len() - 1)]);
        end else if (r < 65) begin
            put_text(op_set[$urandom_range(0, 7)]);
        end else if (r < 75) begin
            put_string();
        end else if (r < 81) begin
            put_char(CH_HASH);
            repeat ($urandom_range(0, 10)) begin
                b = 8'($urandom_range(0, 255));
                put_char(b == CH_LF ? CH_SPACE : b);
            end
            if ($urandom_range(0, 4) == 0) begin
                put_eoi();
            end else begin
                put_char(CH_LF);
            end
        end else if (r < 93) begin
            put_space();
        end else begin
            put_eoi();
        end
    endtask

    // one error per run: the block halts until reset
    task automatic put_fault();
        put_char(CH_SPACE);
        case ($urandom_range(0, 12))
            0:  put_text("@");
            1:  put_char(8'($urandom_range(128, 255)));
            2:  put_text("& ");
            3:  put_text("|a");
            4:  begin
                put_text("\"abc");
                put_eoi();
            end
            5:  put_text("9223372036854775808");
            6:  put_text("2147483648;");
            7:  put_text("!=");
            8:  begin
                put_text("0");
                put_eoi();
            end
            9:  put_text("3.5");
            10: put_text("ab\\c");
            11: put_text("'x\\n'");
            default: put_text("\\x");
        endcase
    endtask

    initial begin
        lex_mode = M_START;
        lex_acc  = '0;
        lex_line = 24'd1;

        put_text("()[]{},:;&&||===<=<>=>_");
        put_eoi();
        put_number(INT32_TOP, 1'b0);
        put_number(INT64_TOP, 1'b1);
        while (char_queue.size() < RANDOM_ITEMS) begin
            put_token();
        end
        put_fault();
        repeat (6) put_char(8'($urandom_range(0, 255)));
        put_eoi();
        chars_total = char_queue.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_taken < chars_total) @(posedge i_clk);
        while (token_fifo.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("filter_language_tokenizer test passed");
        end else begin
            $display("filter_language_tokenizer test failed");
        end
        $finish;
    end

    // ---------------- character driver ----------------

    always @(posedge i_clk) begin
        t_char_item item;
        if (!i_rst_n) begin
            char_ch.valid        <= 1'b0;
            char_ch.char_byte    <= '0;
            char_ch.end_of_input <= 1'b0;
            send_gap             <= 0;
        end else begin
            if (char_ch.valid && char_ch.ready) begin
                lex_byte(char_ch.char_byte, char_ch.end_of_input);
                chars_taken++;
            end
            if (!char_ch.valid || char_ch.ready) begin
                if (send_gap != 0) begin
                    char_ch.valid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end else if (char_queue.size() != 0) begin
                    item = char_queue.pop_front();
                    char_ch.valid        <= 1'b1;
                    char_ch.char_byte    <= item.ch;
                    char_ch.end_of_input <= item.eoi;
                    if ((chars_taken % 96) >= 24) begin
                        send_gap <= pick_gap();
                    end
                end else begin
                    char_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- token receiver and checker ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            token_ch.ready <= 1'b0;
            recv_gap       <= 0;
        end else if (recv_gap != 0) begin
            token_ch.ready <= 1'b0;
            recv_gap       <= recv_gap - 1;
        end else begin
            token_ch.ready <= 1'b1;
            if ((tokens_seen % 80) >= 20) begin
                recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && token_ch.valid && token_ch.ready) begin
            if (token_fifo.size() == 0) begin
                report_fault($sformatf("token %0d with none expected", token_ch.token_code));
            end else begin
                want = token_fifo.pop_front();
                if (token_ch.token_code !== want.token_code)
                    report_fault($sformatf("token_code %0d, expected %0d",
                                           token_ch.token_code, want.token_code));
                if (token_ch.text_byte !== want.text_byte)
                    report_fault($sformatf("text_byte %0h, expected %0h",
                                           token_ch.text_byte, want.text_byte));
                if (token_ch.number_value !== want.number_value)
                    report_fault($sformatf("number_value %0d, expected %0d",
                                           token_ch.number_value, want.number_value));
                if (token_ch.error_code !== want.error_code)
                    report_fault($sformatf("error_code %0d, expected %0d",
                                           token_ch.error_code, want.error_code));
                if (token_ch.line_number !== want.line_number)
                    report_fault($sformatf("line_number %0d, expected %0d",
                                           token_ch.line_number, want.line_number));
                if (token_ch.last_in_run !== want.last_in_run)
                    report_fault($sformatf("last_in_run %0b, expected %0b",
                                           token_ch.last_in_run, want.last_in_run));
            end
            tokens_seen <= tokens_seen + 1;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if ((char_ch.valid && char_ch.ready) || (token_ch.valid && token_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("filter_language_tokenizer test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
